// File: sv/lph_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the linear probe hash table
package lph_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CAP_W          = 11;
    localparam int OP_W           = 2;
    localparam int STATUS_W       = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        t_IDLE,
        t_MOD,
        t_READ,
        t_CHECK,
        t_CLEAR,
        t_DONE,
        t_INIT
    } t_state;

endpackage

// File: sv/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// linear probe hash table top level
// Open-addressing hash table with linear probing and no deletion.
// i_capacity is written through the cfg valid/ready channel while idle;
// values above SLOTS use SLOTS slots.
// Each input transaction (clear, insert, look up, no-op) gives one result transaction.
// Insert and look up: home slot by an iterative modulo, then a synchronous
// memory read and then a compare for each probed slot.
// Clear sweeps the used-bit memory, one slot per cycle.
// One item is in work at a time. Once the result sits in the output register
// a new item is accepted as soon as it is taken; a stalled receiver holds the
// result and the block waits.
// Reset: a clearing pass sweeps every slot of the used-bit store after
// reset, during which no input transaction is accepted.
// Config writes are taken at any time and should only happen while idle.
module linear_probe_hash_table #(
    parameter int SLOTS      = lph_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = lph_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lph_pkg::CAP_W-1:0]     i_capacity,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lph_pkg::OP_W-1:0]      i_opcode,
    input  logic                          i_key_is_bool,
    input  logic signed [KEY_BITS-1:0]    i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lph_pkg::STATUS_W-1:0]  o_status,
    output logic [VALUE_BITS-1:0]         o_found_value,
    output logic [lph_pkg::CAP_W-1:0]     o_entry_total
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CAP_W = lph_pkg::CAP_W;
    localparam int TAG_W = KEY_BITS + 1;

    lph_pkg::t_state r_state, n_state;

    logic [CAP_W-1:0]      r_capacity;
    logic [IDX_W:0]        r_cap_eff;
    logic [lph_pkg::OP_W-1:0] r_op;
    logic [TAG_W-1:0]      r_tag;
    logic [KEY_BITS-1:0]   r_hash;
    logic [VALUE_BITS-1:0] r_val;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W:0]        r_probes, n_probes;
    logic [CAP_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic [lph_pkg::STATUS_W-1:0] r_status, n_status;
    logic [VALUE_BITS-1:0] r_found, n_found;

    logic                  mem_used [SLOTS];
    logic [TAG_W-1:0]      mem_key  [SLOTS];
    logic [VALUE_BITS-1:0] mem_val  [SLOTS];
    logic                  r_rd_used;
    logic [TAG_W-1:0]      r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;

    logic                  w_we_used, w_used_bit, w_we_entry;
    logic                  w_mod_start, w_mod_done;
    logic [IDX_W-1:0]      w_mod_rem;
    logic [TAG_W-1:0]      w_tag;
    logic [KEY_BITS-1:0]   w_hash, w_raw;
    logic [IDX_W-1:0]      w_next_idx;
    logic                  w_accept;
    logic [IDX_W:0]        w_cap_in;

    // tagged key and hash of the incoming item
    always_comb begin
        w_raw = i_key;
        if (i_key_is_bool) begin
            w_raw  = {{(KEY_BITS-1){1'b0}}, i_key[0]};
            w_hash = w_raw;
        end else if (i_key[KEY_BITS-1]) begin
            w_hash = w_raw - 1'b1;
        end else begin
            w_hash = w_raw;
        end
        w_tag = {i_key_is_bool, w_raw};
    end

    always_comb begin
        if ({{(IDX_W+1){1'b0}}, r_capacity} > (IDX_W+1+CAP_W)'(SLOTS)) begin
            w_cap_in = (IDX_W+1)'(SLOTS);
        end else begin
            w_cap_in = (IDX_W+1)'(r_capacity);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_next_idx  = ({1'b0, r_idx} + 1'b1 >= r_cap_eff) ? '0 : r_idx + 1'b1;

    lph_mod #(.KEY_BITS(KEY_BITS), .IDX_W(IDX_W)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_hash),
        .i_divisor  (r_cap_eff),
        .o_done     (w_mod_done),
        .o_remainder(w_mod_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_probes    = r_probes;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_found     = r_found;
        o_ready     = 1'b0;
        w_mod_start = 1'b0;
        w_we_used   = 1'b0;
        w_used_bit  = 1'b0;
        w_we_entry  = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            lph_pkg::t_IDLE: begin
                o_ready = !r_out_valid || i_ready;
                if (i_valid && o_ready) begin
                    n_idx    = '0;
                    n_probes = '0;
                    n_found  = '0;
                    n_status = lph_pkg::ST_OK;
                    case (i_opcode)
                        lph_pkg::OP_CLEAR: begin
                            n_state = lph_pkg::t_CLEAR;
                            n_count = '0;
                        end
                        lph_pkg::OP_INSERT, lph_pkg::OP_LOOKUP: begin
                            n_state = lph_pkg::t_MOD;
                        end
                        default: begin
                            n_state = lph_pkg::t_DONE;
                        end
                    endcase
                end
            end
            lph_pkg::t_MOD: begin
                if (r_cap_eff == '0) begin
                    n_status = (r_op == lph_pkg::OP_INSERT) ?
                               lph_pkg::ST_FULL : lph_pkg::ST_NOT_FOUND;
                    n_state  = lph_pkg::t_DONE;
                end else if (w_mod_done) begin
                    n_idx   = w_mod_rem;
                    n_state = lph_pkg::t_READ;
                end else if (r_probes == '0) begin
                    w_mod_start = 1'b1;
                    n_probes    = (IDX_W+1)'(1);
                end
            end
            lph_pkg::t_READ: begin
                n_state = lph_pkg::t_CHECK;
            end
            lph_pkg::t_CHECK: begin
                if (!r_rd_used) begin
                    if (r_op == lph_pkg::OP_INSERT) begin
                        w_we_used  = 1'b1;
                        w_used_bit = 1'b1;
                        w_we_entry = 1'b1;
                        n_count    = r_count + 1'b1;
                    end else begin
                        n_status = lph_pkg::ST_NOT_FOUND;
                    end
                    n_state = lph_pkg::t_DONE;
                end else if (r_rd_key == r_tag) begin
                    if (r_op == lph_pkg::OP_INSERT) begin
                        n_status = lph_pkg::ST_DUPLICATE;
                    end else begin
                        n_found = r_rd_val;
                    end
                    n_state = lph_pkg::t_DONE;
                end else if (r_probes >= r_cap_eff) begin
                    n_status = (r_op == lph_pkg::OP_INSERT) ?
                               lph_pkg::ST_FULL : lph_pkg::ST_NOT_FOUND;
                    n_state  = lph_pkg::t_DONE;
                end else begin
                    n_idx    = w_next_idx;
                    n_probes = r_probes + 1'b1;
                    n_state  = lph_pkg::t_READ;
                end
            end
            lph_pkg::t_CLEAR, lph_pkg::t_INIT: begin
                w_we_used = 1'b1;
                n_idx     = r_idx + 1'b1;
                if (r_idx == IDX_W'(SLOTS - 1)) begin
                    n_state = (r_state == lph_pkg::t_INIT) ?
                              lph_pkg::t_IDLE : lph_pkg::t_DONE;
                end
            end
            lph_pkg::t_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = lph_pkg::t_IDLE;
                end
            end
            default: begin
                n_state = lph_pkg::t_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lph_pkg::t_INIT;
            r_idx       <= '0;
            r_probes    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_capacity  <= '0;
            r_status    <= lph_pkg::ST_OK;
            r_found     <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_probes    <= n_probes;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_found     <= n_found;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_opcode;
            r_tag     <= w_tag;
            r_hash    <= w_hash;
            r_val     <= i_value;
            r_cap_eff <= w_cap_in;
        end
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (w_we_used) begin
            mem_used[r_idx] <= w_used_bit;
        end
        r_rd_used <= mem_used[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_entry) begin
            mem_key[r_idx] <= r_tag;
            mem_val[r_idx] <= r_val;
        end
        r_rd_key <= mem_key[r_idx];
        r_rd_val <= mem_val[r_idx];
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_entry_total = r_count;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lph_pkg::t_CHECK && r_rd_used && r_rd_key != r_tag
         && r_probes < r_cap_eff) |=> (r_state == lph_pkg::t_READ))
        else $error("probe did not advance");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we_entry |-> (r_op == lph_pkg::OP_INSERT && !r_rd_used))
        else $error("entry written over a used slot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we_entry |=> (r_count == $past(r_count) + 1'b1))
        else $error("count not bumped on insert");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_status) && $stable(r_count)))
        else $error("result changed while stalled");

endmodule

// File: sv/lph_mod.sv
`timescale 1ns / 1ps
// iterative restoring modulo, one quotient bit per cycle
module lph_mod #(
    parameter int KEY_BITS = lph_pkg::KEY_BITS_DEF,
    parameter int IDX_W    = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [KEY_BITS-1:0] i_dividend,
    input  logic [IDX_W:0]      i_divisor,
    output logic                o_done,
    output logic [IDX_W-1:0]    o_remainder
);

    localparam int CNT_W = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] r_num;
    logic [IDX_W+1:0]    r_rem;
    logic [IDX_W:0]      r_div;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [IDX_W+1:0]    w_shift;

    assign w_shift = {r_rem[IDX_W:0], r_num[KEY_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(KEY_BITS);
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_num <= {r_num[KEY_BITS-2:0], 1'b0};
                if (w_shift >= {1'b0, r_div}) begin
                    r_rem <= w_shift - {1'b0, r_div};
                end else begin
                    r_rem <= w_shift;
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem[IDX_W-1:0];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_rem < {1'b0, r_div}))
        else $error("remainder not below divisor");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("start did not launch");

endmodule

// File: tb/linear_probe_hash_table_checker.sv
`timescale 1ns / 1ps
// checker: predicts hash table results from observed transactions and compares them
module linear_probe_hash_table_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [lph_pkg::CAP_W-1:0]     i_capacity,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [lph_pkg::OP_W-1:0]      i_opcode,
    input  logic                          i_key_is_bool,
    input  logic signed [31:0]            i_key,
    input  logic [31:0]                   i_value,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [lph_pkg::STATUS_W-1:0]  i_status,
    input  logic [31:0]                   i_found_value,
    input  logic [lph_pkg::CAP_W-1:0]     i_entry_total,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int NSLOT = 1024;

    typedef struct packed {
        logic [lph_pkg::STATUS_W-1:0] status;
        logic [31:0]                  found;
        logic [lph_pkg::CAP_W-1:0]    total;
    } t_answer;

    logic        tbl_used [NSLOT];
    logic [32:0] tbl_key  [NSLOT];
    logic [31:0] tbl_val  [NSLOT];
    int          tbl_count;
    logic [lph_pkg::CAP_W-1:0] tbl_cap;
    t_answer     answer_q[$];

    // returns 1 match, 0 empty slot, -1 full
    function automatic int probe_slot(input logic [32:0] tag_key, input logic [31:0] hash,
                                      output int where);
        int cap;
        int idx;
        cap = (tbl_cap > NSLOT) ? NSLOT : int'(tbl_cap);
        where = 0;
        if (cap == 0) return -1;
        idx = int'(hash % cap);
        for (int n = 0; n < cap; n++) begin
            if (!tbl_used[idx]) begin
                where = idx;
                return 0;
            end
            if (tbl_key[idx] == tag_key) begin
                where = idx;
                return 1;
            end
            idx = (idx + 1 >= cap) ? 0 : idx + 1;
        end
        return -1;
    endfunction

    function automatic t_answer apply_op(input logic [lph_pkg::OP_W-1:0] op, input logic kb,
                                         input logic [31:0] raw_in, input logic [31:0] val);
        t_answer a;
        logic [31:0] raw;
        logic [31:0] hash;
        logic [32:0] tag_key;
        int where;
        int r;
        a = '0;
        raw = raw_in;
        if (kb) begin
            raw = {31'd0, raw_in[0]};
            hash = raw;
        end else if (raw[31]) begin
            hash = 32'hFFFF_FFFF - (32'd0 - raw);
        end else begin
            hash = raw;
        end
        tag_key = {kb, raw};
        case (op)
            lph_pkg::OP_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
                tbl_count = 0;
            end
            lph_pkg::OP_INSERT: begin
                r = probe_slot(tag_key, hash, where);
                if (r < 0) a.status = lph_pkg::ST_FULL;
                else if (r > 0) a.status = lph_pkg::ST_DUPLICATE;
                else begin
                    tbl_used[where] = 1'b1;
                    tbl_key[where] = tag_key;
                    tbl_val[where] = val;
                    tbl_count++;
                end
            end
            lph_pkg::OP_LOOKUP: begin
                r = probe_slot(tag_key, hash, where);
                if (r > 0) a.found = tbl_val[where];
                else a.status = lph_pkg::ST_NOT_FOUND;
            end
            default: ;
        endcase
        a.total = tbl_count[lph_pkg::CAP_W-1:0];
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
            tbl_count = 0;
            tbl_cap <= '0;
            answer_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) tbl_cap <= i_capacity;
            if (i_out_valid && i_out_ready) begin
                got = '{i_status, i_found_value, i_entry_total};
                if (answer_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result transaction %p", got);
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                answer_q.push_back(apply_op(i_opcode, i_key_is_bool, i_key, i_value));
            o_pending <= answer_q.size();
        end
    end
endmodule

// File: tb/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps
// testbench top: stimulus, idling phases and verdict for the linear probe hash table
module linear_probe_hash_table_tb;

    logic i_clk, i_rst_n;
    logic cfg_valid, cfg_ready;
    logic [lph_pkg::CAP_W-1:0] cfg_cap;
    logic in_valid, in_ready;
    logic [lph_pkg::OP_W-1:0] in_op;
    logic in_kb;
    logic signed [31:0] in_key;
    logic [31:0] in_value;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [lph_pkg::STATUS_W-1:0] out_status;
    logic [31:0] out_found;
    logic [lph_pkg::CAP_W-1:0] out_total;
    int fail_count, pending;
    int send_idle_pct, recv_stall_pct;
    logic hold_req;
    logic hold_taken = 1'b0;
    int hold_off = 0;
    int quiet_cycles = 0;
    int key_pool[16];

    linear_probe_hash_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_capacity(cfg_cap),
        .i_valid(in_valid), .o_ready(in_ready), .i_opcode(in_op),
        .i_key_is_bool(in_kb), .i_key(in_key), .i_value(in_value),
        .o_valid(out_valid), .i_ready(out_ready), .o_status(out_status),
        .o_found_value(out_found), .o_entry_total(out_total)
    );

    linear_probe_hash_table_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_capacity(cfg_cap),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_opcode(in_op),
        .i_key_is_bool(in_kb), .i_key(in_key), .i_value(in_value),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_status(out_status),
        .i_found_value(out_found), .i_entry_total(out_total),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_off   <= 400;
            out_ready  <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("linear_probe_hash_table_tb NOT OK");
            $finish;
        end
    end

    task automatic send_item(input logic [lph_pkg::OP_W-1:0] op, input logic kb,
                             input logic [31:0] k, input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_kb <= kb;
        in_key <= k;
        in_value <= v;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int cap);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_cap <= cap[lph_pkg::CAP_W-1:0];
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(input int n, input int key_span);
        logic [lph_pkg::OP_W-1:0] op;
        logic [31:0] k;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 2) op = lph_pkg::OP_CLEAR;
            else if (r < 4) op = lph_pkg::OP_NOP;
            else if (r < 55) op = lph_pkg::OP_INSERT;
            else op = lph_pkg::OP_LOOKUP;
            if ($urandom_range(9) < 7) k = key_pool[$urandom_range(15)] + $urandom_range(key_span);
            else k = $urandom;
            send_item(op, ($urandom_range(9) == 0), k, $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_cap = '0;
        in_valid = 1'b0;
        in_op = lph_pkg::OP_CLEAR;
        in_kb = 1'b0;
        in_key = '0;
        in_value = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
        key_pool[0] = 0;
        key_pool[1] = -8;
        key_pool[2] = 32'h7FFF_FFF0;
        key_pool[3] = 32'h8000_0000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero capacity
        send_item(lph_pkg::OP_INSERT, 1'b0, 32'd5, 32'hFFFF_FFFF);
        send_item(lph_pkg::OP_LOOKUP, 1'b0, 32'd5, 32'd0);
        write_capacity(3);
        send_item(lph_pkg::OP_INSERT, 1'b0, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
        send_item(lph_pkg::OP_INSERT, 1'b0, 32'h8000_0000, 32'h1);
        send_item(lph_pkg::OP_INSERT, 1'b1, 32'hFFFF_FFFE, 32'h2);
        send_item(lph_pkg::OP_INSERT, 1'b0, 32'd1, 32'h3);
        send_item(lph_pkg::OP_INSERT, 1'b0, 32'h7FFF_FFFF, 32'h4);
        send_item(lph_pkg::OP_LOOKUP, 1'b1, 32'd0, 32'd0);
        send_item(lph_pkg::OP_LOOKUP, 1'b0, 32'd0, 32'd0);
        send_item(lph_pkg::OP_LOOKUP, 1'b0, 32'h8000_0000, 32'd0);
        send_item(lph_pkg::OP_NOP, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_capacity(1);
        send_item(lph_pkg::OP_LOOKUP, 1'b0, 32'h7FFF_FFFF, 32'd0);
        send_item(lph_pkg::OP_INSERT, 1'b1, 32'd1, 32'd9);
        send_item(lph_pkg::OP_CLEAR, 1'b0, 32'd0, 32'd0);
        send_item(lph_pkg::OP_INSERT, 1'b1, 32'd3, 32'd7);
        send_item(lph_pkg::OP_LOOKUP, 1'b1, 32'd1, 32'd0);
        write_capacity(2047);
        send_item(lph_pkg::OP_INSERT, 1'b0, 32'hFFFF_FFFF, 32'd8);
        send_item(lph_pkg::OP_LOOKUP, 1'b0, 32'hFFFF_FFFF, 32'd0);
        send_item(lph_pkg::OP_CLEAR, 1'b0, 32'd0, 32'd0);

        write_capacity(7);
        random_items(100, 12);
        send_idle_pct = 61;
        write_capacity(16);
        random_items(100, 30);
        send_idle_pct = 0;
        recv_stall_pct = 61;
        write_capacity(1024);
        random_items(100, 2000);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        write_capacity(5);
        random_items(100, 8);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_capacity(0);
        random_items(20, 4);
        write_capacity(64);
        hold_req = 1'b1;
        random_items(80, 100);

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        if (fail_count == 0)
            $display("linear_probe_hash_table_tb OK");
        else
            $display("linear_probe_hash_table_tb NOT OK");
        $finish;
    end
endmodule

// File: linear_probe_hash_table.f
sv/lph_pkg.sv
sv/lph_mod.sv
sv/linear_probe_hash_table.sv
tb/linear_probe_hash_table_checker.sv
tb/linear_probe_hash_table_tb.sv
